[hw/rtl/mcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared types and constants of the message chunk fragmenter.
// ----------------------------------------------------------------------------
package mcf_pkg;

  localparam int PACKET_LIMIT        = 1200;
  localparam int TRANSPORT_OVERHEAD  = 50;
  localparam int HEADER_BYTES        = 16;
  localparam int PAYLOAD_RESET       = PACKET_LIMIT - TRANSPORT_OVERHEAD - HEADER_BYTES;
  localparam int LENGTH_BITS_DEFAULT = 16;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int CFG_W      = 16;
  localparam logic [0:0] REG_CHUNK_PAYLOAD = 1'b0;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] message_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunked;
    logic       packet_end;
    logic       run_last;
  } out_item_t;

endpackage

[hw/rtl/mcf_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcf_regs
// Configuration register file on an APB-style port.
// ----------------------------------------------------------------------------
module mcf_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mcf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mcf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mcf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [mcf_pkg::CFG_W-1:0]      chunk_payload_o
);
  import mcf_pkg::*;

  logic [CFG_W-1:0] chunk_payload_q;
  logic             reg_sel;
  logic             wr_en;

  // word index is the address bit above the byte offset
  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_CHUNK_PAYLOAD);
  assign wr_en   = psel && penable && pwrite && reg_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_payload_q <= CFG_W'(PAYLOAD_RESET);
    end else if (wr_en) begin
      chunk_payload_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = APB_DATA_W'(chunk_payload_q);
    end
  end

  assign pready          = 1'b1;
  assign chunk_payload_o = chunk_payload_q;

endmodule

[hw/rtl/mcf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcf_div #(
  parameter int W = 17
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quotient_o
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, quo_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [W:0]    shifted;
  logic [W+1:0]  diff;
  logic          ge;
  logic [W-1:0]  rem_d;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = !diff[W+1];
  assign rem_d   = ge ? diff[W-1:0] : shifted[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[hw/rtl/message_chunk_fragmenter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_chunk_fragmenter
// Cuts a message byte stream into whole-message or headered chunk packets.
// ----------------------------------------------------------------------------
// sequence: a byte that opens no chunk goes from its request through the data
//   step into the output register; one that opens a chunk first passes a size
//   step and 16 header bytes before its data byte, and the first byte of a
//   chunked message also waits for the total-chunks division
// flow: one request at a time, a new one is taken only once the sequencer is
//   back in idle; the output register frees up as results are taken
// reset: asynchronous, clears frame counter and message state, payload 1134
module message_chunk_fragmenter #(
  parameter int LENGTH_BITS = mcf_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mcf_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mcf_pkg::out_item_t             out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mcf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mcf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mcf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mcf_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam int DW = LB + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SIZE = 3'd2;
  localparam logic [2:0] S_HDR  = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;

  localparam logic [1:0] HDR_FRAME = 2'd0;
  localparam logic [1:0] HDR_INDEX = 2'd1;
  localparam logic [1:0] HDR_TOTAL = 2'd2;
  localparam logic [1:0] HDR_SIZE  = 2'd3;

  logic [CFG_W-1:0] cfg_payload;
  logic [2:0]       state_q;
  logic [31:0]      frame_q;
  logic [LB-1:0]    pos_q, idx_q, total_q, left_q;
  logic [LB-1:0]    len_q, pay_q;
  logic [7:0]       byte_q;
  logic [3:0]       hdr_cnt_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [LB-1:0]    pay_raw, pay_eff, len_in;
  logic             accept, need_div, slot_free, out_load;
  logic [DW-1:0]    div_dividend, div_quotient;
  logic             div_done;
  logic             msg_end;
  logic [LB-1:0]    remain, next_size, left_dec;
  logic [31:0]      hdr_word;
  logic [4:0]       hdr_shift;
  logic [7:0]       hdr_byte;

  mcf_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .chunk_payload_o (cfg_payload)
  );

  assign pay_raw   = LB'(cfg_payload);
  assign pay_eff   = (pay_raw == '0) ? LB'(1) : pay_raw;
  assign len_in    = LB'(in_data_i.message_length);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept    = in_valid_i && in_ready_o;
  assign need_div  = (pos_q == '0) && (len_in > pay_eff);
  assign slot_free = !out_valid_q || out_ready_i;
  assign out_load  = slot_free && (state_q inside {S_HDR, S_DATA});

  // ceil(len / pay) as floor((len + pay - 1) / pay)
  assign div_dividend = {1'b0, len_in} + {1'b0, pay_eff} - DW'(1);

  mcf_div #(.W(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && need_div),
    .dividend_i (div_dividend),
    .divisor_i  ({1'b0, pay_eff}),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign msg_end    = ({1'b0, pos_q} + DW'(1)) >= {1'b0, len_q};
  assign remain     = (len_q > pos_q) ? (len_q - pos_q) : LB'(1);
  assign next_size  = (remain < pay_q) ? remain : pay_q;
  assign left_dec   = left_q - LB'(1);

  always_comb begin
    case (hdr_cnt_q[3:2])
      HDR_FRAME: hdr_word = frame_q;
      HDR_INDEX: hdr_word = 32'(idx_q);
      HDR_TOTAL: hdr_word = 32'(total_q);
      HDR_SIZE:  hdr_word = 32'(left_q);
      default:   hdr_word = '0;
    endcase
  end

  // big-endian: byte 0 of a word is bits 31:24
  assign hdr_shift = {~hdr_cnt_q[1:0], 3'b000};
  assign hdr_byte  = 8'(hdr_word >> hdr_shift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      frame_q     <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      total_q     <= '0;
      left_q      <= '0;
      hdr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (need_div) begin
              frame_q <= frame_q + 32'd1;
              idx_q   <= '0;
              left_q  <= '0;
              state_q <= S_DIV;
            end else if (pos_q == '0) begin
              total_q <= '0;
              state_q <= S_DATA;
            end else if ((total_q != '0) && (left_q == '0)) begin
              state_q <= S_SIZE;
            end else begin
              state_q <= S_DATA;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            total_q <= div_quotient[LB-1:0];
            state_q <= S_SIZE;
          end
        end
        S_SIZE: begin
          left_q    <= next_size;
          hdr_cnt_q <= '0;
          state_q   <= S_HDR;
        end
        S_HDR: begin
          if (slot_free) begin
            hdr_cnt_q   <= hdr_cnt_q + 4'd1;
            if (hdr_cnt_q == 4'(HEADER_BYTES - 1)) begin
              state_q <= S_DATA;
            end
          end
        end
        S_DATA: begin
          if (slot_free) begin
            state_q     <= S_IDLE;
            if (msg_end) begin
              pos_q   <= '0;
              idx_q   <= '0;
              total_q <= '0;
              left_q  <= '0;
            end else begin
              pos_q <= pos_q + LB'(1);
              if (total_q != '0) begin
                left_q <= left_dec;
                if (left_dec == '0) begin
                  idx_q <= idx_q + LB'(1);
                end
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_data_i.data_byte;
      len_q  <= len_in;
      pay_q  <= pay_eff;
    end
    if ((state_q == S_HDR) && slot_free) begin
      out_q.out_byte   <= hdr_byte;
      out_q.chunked    <= 1'b1;
      out_q.packet_end <= 1'b0;
      out_q.run_last   <= 1'b0;
    end else if ((state_q == S_DATA) && slot_free) begin
      out_q.out_byte   <= byte_q;
      out_q.chunked    <= (total_q != '0);
      out_q.packet_end <= msg_end || ((total_q != '0) && (left_dec == '0));
      out_q.run_last   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request taken while the previous one is still in work");

  a_div_on_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (pos_q == '0))
    else $error("chunk count division outside the first byte of a message");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished while the sequencer was not waiting");

  a_header_needs_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HDR) |-> (total_q != '0))
    else $error("chunk header sent with no chunked message open");
`endif

endmodule

[bench/message_chunk_fragmenter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_chunk_fragmenter_tb
// Drives message bytes with random gaps and output stalls, rewrites the chunk
// payload register between phases and checks every published byte against an
// in-bench model of the fragmenter.
// ----------------------------------------------------------------------------
module message_chunk_fragmenter_tb;
  import mcf_pkg::*;

  localparam int TOTAL_ITEMS   = 270;
  localparam int QUIET_AFTER   = TOTAL_ITEMS - 40;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam logic [APB_ADDR_W-1:0] PAYLOAD_ADDR = APB_ADDR_W'(4 * REG_CHUNK_PAYLOAD);

  class fragment_scoreboard;
    logic [15:0] payload_reg;
    logic [31:0] frame_no;
    logic [15:0] byte_pos;
    logic [15:0] chunk_idx;
    logic [15:0] chunk_cnt;
    logic [15:0] chunk_left;
    out_item_t   packet_q[$];
    int unsigned errors;

    function new();
      payload_reg = 16'(PAYLOAD_RESET);
      frame_no    = '0;
      errors      = 0;
      clear_message();
    endfunction

    function void clear_message();
      byte_pos   = '0;
      chunk_idx  = '0;
      chunk_cnt  = '0;
      chunk_left = '0;
    endfunction

    function void push(logic [7:0] b, logic chunk, logic pend, logic last);
      packet_q.insert(packet_q.size(), out_item_t'{out_byte: b, chunked: chunk,
                                                   packet_end: pend, run_last: last});
    endfunction

    // works out every byte published for one accepted request
    function void note_request(in_item_t req);
      logic [15:0] pay;
      logic [15:0] remain;
      logic [15:0] size;
      logic [31:0] words [4];
      bit          done;
      pay  = (payload_reg == '0) ? 16'd1 : payload_reg;
      done = ({16'd0, byte_pos} + 32'd1) >= {16'd0, req.message_length};
      if (byte_pos == '0) begin
        if (req.message_length > pay) begin
          frame_no   = frame_no + 32'd1;
          chunk_cnt  = 16'(({16'd0, req.message_length} + {16'd0, pay} - 32'd1)
                           / {16'd0, pay});
          chunk_idx  = '0;
          chunk_left = '0;
        end else begin
          chunk_cnt = '0;
        end
      end
      if (chunk_cnt == '0) begin
        push(req.data_byte, 1'b0, done, 1'b1);
        if (done) clear_message();
        else byte_pos = byte_pos + 16'd1;
        return;
      end
      if (chunk_left == '0) begin
        // a length that fell below the position still opens a one-byte chunk
        remain = (req.message_length > byte_pos) ? req.message_length - byte_pos : 16'd1;
        size   = (remain < pay) ? remain : pay;
        words  = '{frame_no, {16'd0, chunk_idx}, {16'd0, chunk_cnt}, {16'd0, size}};
        foreach (words[w]) begin
          for (int b = 3; b >= 0; b--) push(words[w][8*b +: 8], 1'b1, 1'b0, 1'b0);
        end
        chunk_left = size;
      end
      chunk_left = chunk_left - 16'd1;
      push(req.data_byte, 1'b1, done || chunk_left == '0, 1'b1);
      if (done) begin
        clear_message();
      end else begin
        byte_pos = byte_pos + 16'd1;
        if (chunk_left == '0) chunk_idx = chunk_idx + 16'd1;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (packet_q.size() == 0) begin
        $error("unexpected result, out_byte %0h", got.out_byte);
        errors++;
        return;
      end
      want = packet_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.chunked !== want.chunked) begin
        $error("chunked: expected %0b, got %0b", want.chunked, got.chunked);
        errors++;
      end
      if (got.packet_end !== want.packet_end) begin
        $error("packet_end: expected %0b, got %0b", want.packet_end, got.packet_end);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fragment_scoreboard sb;
  bit quiet;
  int items_sent;
  int cycle_count;

  message_chunk_fragmenter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // output stalls in random bursts, none in the closing stretch
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  task automatic send_request(logic [7:0] b, logic [15:0] len);
    in_item_t req;
    req.data_byte      = b;
    req.message_length = len;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
    items_sent++;
  endtask

  task automatic send_message(logic [15:0] len, int count);
    repeat (count) send_request(8'($urandom_range(0, 255)), len);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.packet_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_payload(logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAYLOAD_ADDR;
    pwdata  <= {{(APB_DATA_W - CFG_W){1'b0}}, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.payload_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[CFG_W-1:0] !== value) begin
      $error("chunk_payload_bytes: expected %0d, got %0d", value, prdata[CFG_W-1:0]);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int          kind;
    logic [15:0] len;
    logic [15:0] pay;
    sb         = new();
    quiet      = 1'b0;
    items_sent = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset payload size: short messages go out whole
    send_request(8'h00, 16'd1);
    send_request(8'hFF, 16'd0);
    send_request(8'hFF, 16'd2);
    send_request(8'h00, 16'd2);
    wait_drained();
    write_payload(16'd4);
    send_message(16'd10, 10);
    // long message cut short by a smaller length
    send_message(16'hFFFF, 2);
    send_request(8'h5A, 16'd3);
    send_message(16'd20, 4);
    // payload changes while a message is open
    wait_drained();
    write_payload(16'd2);
    // next chunk opens with the length already behind the position
    send_request(8'hC3, 16'd3);
    wait_drained();
    write_payload(16'd0);
    send_message(16'd2, 2);
    wait_drained();
    write_payload(16'hFFFF);
    send_request(8'h81, 16'hFFFF);
    send_request(8'h7E, 16'd1);

    while (items_sent < TOTAL_ITEMS) begin
      wait_drained();
      case ($urandom_range(0, 7))
        0:       pay = 16'd0;
        1:       pay = 16'd1;
        2:       pay = 16'hFFFF;
        3:       pay = 16'(PAYLOAD_RESET);
        default: pay = 16'($urandom_range(2, 12));
      endcase
      write_payload(pay);
      repeat ($urandom_range(2, 5)) begin
        if (items_sent >= TOTAL_ITEMS) break;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
          len = 16'($urandom_range(1, 40));
          send_message(len, len);
        end else if (kind == 7) begin
          // truncated: random full-width length, then closed by a tiny one
          send_message(16'($urandom_range(0, 16'hFFFF)), $urandom_range(1, 6));
          send_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 1)));
        end else if (kind == 8) begin
          send_message(16'($urandom_range(1, 40)), $urandom_range(1, 8));
          len = 16'($urandom_range(1, 40));
          while (sb.byte_pos != '0) send_request(8'($urandom_range(0, 255)), len);
        end else begin
          send_request(8'($urandom_range(0, 255)), 16'd0);
        end
        if (items_sent >= QUIET_AFTER) quiet = 1'b1;
      end
      // sometimes leave a message open across the next register write
      if ($urandom_range(0, 2) == 0)
        send_message(16'($urandom_range(20, 40)), $urandom_range(1, 8));
    end

    in_valid_i <= 1'b0;
    while (sb.packet_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.packet_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/mcf_pkg.sv
hw/rtl/mcf_regs.sv
hw/rtl/mcf_div.sv
hw/rtl/message_chunk_fragmenter.sv
bench/message_chunk_fragmenter_tb.sv
